>>> rtl/bgi_pkg.sv
// ----------------------------------------------------------------------------
// bgi_pkg
// Shared constants, widths and codes for the bilinear grid interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package bgi_pkg;

  // Grid geometry (power-of-two sizes, banked 2x2 by column/row parity)
  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int ROW_W     = $clog2(GRID_ROWS);

  // Fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;

  // Four banks, one per (row parity, column parity) pair
  localparam int NUM_BANKS  = 4;
  localparam int BANK_SEL_W = 2;
  localparam int BANK_AW    = (COL_W - 1) + (ROW_W - 1);
  localparam int BANK_DEPTH = (GRID_COLS / 2) * (GRID_ROWS / 2);

  // Scaled coordinate: 32x32 product with the fraction shifted out
  localparam int CX_W   = 2 * DATA_W - FRAC_BITS;
  localparam int CRDX_W = COL_W + FRAC_BITS;
  localparam int CRDY_W = ROW_W + FRAC_BITS;

  // Lerp product: 33-bit difference times unsigned weight, plus headroom
  localparam int PROD_W = DATA_W + FRAC_BITS + 2;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_SIZE_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = CFG_IDX_W'(5);

  localparam logic [DATA_W-1:0]     SCALE_ONE  = DATA_W'(1) << FRAC_BITS;
  localparam logic [CFG_SIZE_W-1:0] COLS_RESET = CFG_SIZE_W'(GRID_COLS);
  localparam logic [CFG_SIZE_W-1:0] ROWS_RESET = CFG_SIZE_W'(GRID_ROWS);

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

`default_nettype wire

>>> rtl/bilinear_grid_interpolator.sv
// ----------------------------------------------------------------------------
// bilinear_grid_interpolator
// Grid of signed Q16.16 samples with write and bilinear query items.
// ----------------------------------------------------------------------------
// A query result passes through stage registers s1 to s9 and the output
// register; writes take effect in the memory stage and produce no result.
// Throughput: one item per cycle unless held; the four neighbors come from four
// parity banks, one read port each, so the memory is read once per item.
// The whole pipeline holds while an unaccepted result sits in the output.
// Reset (synchronous, rst_n low) clears valid bits and configuration; grid
// contents stay undefined until written.
`default_nettype none

module bilinear_grid_interpolator (
  input  wire                               clk,
  input  wire                               rst_n,
  // configuration write port
  input  wire                               cfg_we,
  input  wire  [bgi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [bgi_pkg::DATA_W-1:0]        cfg_wdata,
  // input item channel
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               in_mode,
  input  wire  signed [bgi_pkg::DATA_W-1:0] in_pos_x,
  input  wire  signed [bgi_pkg::DATA_W-1:0] in_pos_y,
  input  wire  [bgi_pkg::COL_W-1:0]         in_write_col,
  input  wire  [bgi_pkg::ROW_W-1:0]         in_write_row,
  input  wire  signed [bgi_pkg::DATA_W-1:0] in_write_value,
  // result channel
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [bgi_pkg::DATA_W-1:0] out_interp_value
);

  localparam int DW = bgi_pkg::DATA_W;
  localparam int FB = bgi_pkg::FRAC_BITS;
  localparam int CW = bgi_pkg::COL_W;
  localparam int RW = bgi_pkg::ROW_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0]                  origin_x_r, origin_y_r;
  logic [DW-1:0]                         scale_x_r, scale_y_r;
  logic [bgi_pkg::CFG_SIZE_W-1:0]        cols_r, rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      scale_x_r  <= bgi_pkg::SCALE_ONE;
      scale_y_r  <= bgi_pkg::SCALE_ONE;
      cols_r     <= bgi_pkg::COLS_RESET;
      rows_r     <= bgi_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bgi_pkg::REG_ORIGIN_X:    origin_x_r <= cfg_wdata;
        bgi_pkg::REG_ORIGIN_Y:    origin_y_r <= cfg_wdata;
        bgi_pkg::REG_SCALE_X:     scale_x_r  <= cfg_wdata;
        bgi_pkg::REG_SCALE_Y:     scale_y_r  <= cfg_wdata;
        bgi_pkg::REG_COLS_IN_USE: cols_r     <= cfg_wdata[bgi_pkg::CFG_SIZE_W-1:0];
        bgi_pkg::REG_ROWS_IN_USE: rows_r     <= cfg_wdata[bgi_pkg::CFG_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero counts as one, oversize saturates to the grid
  logic [bgi_pkg::CFG_SIZE_W-1:0] ncols, nrows;
  logic [CW-1:0]                  ncm1_x;
  logic [RW-1:0]                  ncm1_y;
  logic [bgi_pkg::CRDX_W-1:0]     maxc_x;
  logic [bgi_pkg::CRDY_W-1:0]     maxc_y;

  always_comb begin
    if (cols_r == '0)                    ncols = bgi_pkg::CFG_SIZE_W'(1);
    else if (cols_r > bgi_pkg::COLS_RESET) ncols = bgi_pkg::COLS_RESET;
    else                                 ncols = cols_r;
    if (rows_r == '0)                    nrows = bgi_pkg::CFG_SIZE_W'(1);
    else if (rows_r > bgi_pkg::ROWS_RESET) nrows = bgi_pkg::ROWS_RESET;
    else                                 nrows = rows_r;
    ncm1_x = CW'(ncols - bgi_pkg::CFG_SIZE_W'(1));
    ncm1_y = RW'(nrows - bgi_pkg::CFG_SIZE_W'(1));
    maxc_x = {ncm1_x, FB'(0)};
    maxc_y = {ncm1_y, FB'(0)};
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: everything holds while the output is full and stalled
  // ---------------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Valid bits (stages 1-3 carry writes and queries, later ones queries only)
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic s5_valid_r, s6_valid_r, s7_valid_r, s8_valid_r, s9_valid_r;
  logic s3_query_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      s7_valid_r  <= 1'b0;
      s8_valid_r  <= 1'b0;
      s9_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r && s3_query_r;
      s5_valid_r  <= s4_valid_r;
      s6_valid_r  <= s5_valid_r;
      s7_valid_r  <= s6_valid_r;
      s8_valid_r  <= s7_valid_r;
      s9_valid_r  <= s8_valid_r;
      out_valid_r <= s9_valid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: offset from origin, negative or zero distance maps to zero
  // ---------------------------------------------------------------------------
  logic                 s1_query_r;
  logic [DW-1:0]        s1_dx_r, s1_dy_r;
  logic [CW-1:0]        s1_wcol_r;
  logic [RW-1:0]        s1_wrow_r;
  logic signed [DW-1:0] s1_wval_r;
  logic signed [DW:0]   d_x, d_y;
  logic [DW-1:0]        s1_dx_nxt, s1_dy_nxt;

  always_comb begin
    d_x = $signed({in_pos_x[DW-1], in_pos_x}) - $signed({origin_x_r[DW-1], origin_x_r});
    d_y = $signed({in_pos_y[DW-1], in_pos_y}) - $signed({origin_y_r[DW-1], origin_y_r});
    s1_dx_nxt = (d_x[DW] || d_x == '0) ? '0 : d_x[DW-1:0];
    s1_dy_nxt = (d_y[DW] || d_y == '0) ? '0 : d_y[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_query_r <= (in_mode == bgi_pkg::MODE_QUERY);
      s1_dx_r    <= s1_dx_nxt;
      s1_dy_r    <= s1_dy_nxt;
      s1_wcol_r  <= in_write_col;
      s1_wrow_r  <= in_write_row;
      s1_wval_r  <= in_write_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: scale into grid units (one 32x32 multiply per axis)
  // ---------------------------------------------------------------------------
  logic                     s2_query_r;
  logic [bgi_pkg::CX_W-1:0] s2_cx_r, s2_cy_r;
  logic [CW-1:0]            s2_wcol_r;
  logic [RW-1:0]            s2_wrow_r;
  logic signed [DW-1:0]     s2_wval_r;
  logic [2*DW-1:0]          mul_x, mul_y;

  always_comb begin
    mul_x = {{DW{1'b0}}, s1_dx_r} * {{DW{1'b0}}, scale_x_r};
    mul_y = {{DW{1'b0}}, s1_dy_r} * {{DW{1'b0}}, scale_y_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_query_r <= s1_query_r;
      s2_cx_r    <= mul_x[2*DW-1:FB];
      s2_cy_r    <= mul_y[2*DW-1:FB];
      s2_wcol_r  <= s1_wcol_r;
      s2_wrow_r  <= s1_wrow_r;
      s2_wval_r  <= s1_wval_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: clamp to the used extent, split integer and weight
  // ---------------------------------------------------------------------------
  logic [CW-1:0]              s3_x1_r;
  logic [RW-1:0]              s3_y1_r;
  logic                       s3_xinc_r, s3_yinc_r;
  logic [FB-1:0]              s3_tx_r, s3_ty_r;
  logic [CW-1:0]              s3_wcol_r;
  logic [RW-1:0]              s3_wrow_r;
  logic signed [DW-1:0]       s3_wval_r;
  logic [bgi_pkg::CRDX_W-1:0] cx_cl;
  logic [bgi_pkg::CRDY_W-1:0] cy_cl;
  logic                       gt_x, gt_y, lt_x, lt_y;

  always_comb begin
    gt_x  = s2_cx_r > bgi_pkg::CX_W'(maxc_x);
    gt_y  = s2_cy_r > bgi_pkg::CX_W'(maxc_y);
    lt_x  = s2_cx_r < bgi_pkg::CX_W'(maxc_x);
    lt_y  = s2_cy_r < bgi_pkg::CX_W'(maxc_y);
    cx_cl = gt_x ? maxc_x : s2_cx_r[bgi_pkg::CRDX_W-1:0];
    cy_cl = gt_y ? maxc_y : s2_cy_r[bgi_pkg::CRDY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_query_r <= s2_query_r;
      s3_x1_r    <= cx_cl[bgi_pkg::CRDX_W-1:FB];
      s3_y1_r    <= cy_cl[bgi_pkg::CRDY_W-1:FB];
      s3_tx_r    <= cx_cl[FB-1:0];
      s3_ty_r    <= cy_cl[FB-1:0];
      s3_xinc_r  <= lt_x;
      s3_yinc_r  <= lt_y;
      s3_wcol_r  <= s2_wcol_r;
      s3_wrow_r  <= s2_wrow_r;
      s3_wval_r  <= s2_wval_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: banked grid memory. Bank {row parity, column parity}; the even
  // and odd neighbor of x1 sit at (x1 + x1[0]) >> 1 and x1 >> 1.
  // ---------------------------------------------------------------------------
  logic [CW:0]                  x1_up;
  logic [RW:0]                  y1_up;
  logic [CW-2:0]                x_even, x_odd;
  logic [RW-2:0]                y_even, y_odd;
  logic [bgi_pkg::BANK_AW-1:0]  bank_addr [bgi_pkg::NUM_BANKS];
  logic [bgi_pkg::NUM_BANKS-1:0] bank_we;
  logic signed [DW-1:0]         bank_rd_r [bgi_pkg::NUM_BANKS];

  always_comb begin
    x1_up  = {1'b0, s3_x1_r} + (CW+1)'(s3_x1_r[0]);
    y1_up  = {1'b0, s3_y1_r} + (RW+1)'(s3_y1_r[0]);
    x_even = x1_up[CW-1:1];
    y_even = y1_up[RW-1:1];
    x_odd  = s3_x1_r[CW-1:1];
    y_odd  = s3_y1_r[RW-1:1];
    for (int b = 0; b < bgi_pkg::NUM_BANKS; b++) begin
      logic [bgi_pkg::BANK_SEL_W-1:0] bsel;
      bsel = bgi_pkg::BANK_SEL_W'(b);
      if (s3_query_r) begin
        bank_addr[b] = {(bsel[1] ? y_odd : y_even), (bsel[0] ? x_odd : x_even)};
      end else begin
        bank_addr[b] = {s3_wrow_r[RW-1:1], s3_wcol_r[CW-1:1]};
      end
      bank_we[b] = en && s3_valid_r && !s3_query_r &&
                   (s3_wrow_r[0] == bsel[1]) && (s3_wcol_r[0] == bsel[0]);
    end
  end

  for (genvar gb = 0; gb < bgi_pkg::NUM_BANKS; gb++) begin : g_bank
    logic signed [DW-1:0] bank_mem [bgi_pkg::BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (bank_we[gb]) begin
        bank_mem[bank_addr[gb]] <= s3_wval_r;
      end
      if (en) begin
        bank_rd_r[gb] <= bank_mem[bank_addr[gb]];
      end
    end
  end

  logic          s4_px_r, s4_py_r, s4_xinc_r, s4_yinc_r;
  logic [FB-1:0] s4_tx_r, s4_ty_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_px_r   <= s3_x1_r[0];
      s4_py_r   <= s3_y1_r[0];
      s4_xinc_r <= s3_xinc_r;
      s4_yinc_r <= s3_yinc_r;
      s4_tx_r   <= s3_tx_r;
      s4_ty_r   <= s3_ty_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: route banks to the four corners, differences along y
  // ---------------------------------------------------------------------------
  logic                           px2, py2;
  logic [bgi_pkg::BANK_SEL_W-1:0] sel11, sel12, sel21, sel22;
  logic signed [DW-1:0]           v11, v12, v21, v22;
  logic signed [DW-1:0]           s5_al_r, s5_ar_r;
  logic signed [DW:0]             s5_dl_r, s5_dr_r;
  logic [FB-1:0]                  s5_tx_r, s5_ty_r;

  always_comb begin
    px2   = s4_px_r ^ s4_xinc_r;
    py2   = s4_py_r ^ s4_yinc_r;
    sel11 = {s4_py_r, s4_px_r};
    sel12 = {py2, s4_px_r};
    sel21 = {s4_py_r, px2};
    sel22 = {py2, px2};
    v11   = bank_rd_r[sel11];
    v12   = bank_rd_r[sel12];
    v21   = bank_rd_r[sel21];
    v22   = bank_rd_r[sel22];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_al_r <= v11;
      s5_ar_r <= v21;
      s5_dl_r <= $signed({v12[DW-1], v12}) - $signed({v11[DW-1], v11});
      s5_dr_r <= $signed({v22[DW-1], v22}) - $signed({v21[DW-1], v21});
      s5_tx_r <= s4_tx_r;
      s5_ty_r <= s4_ty_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: weight the y differences
  // ---------------------------------------------------------------------------
  logic signed [bgi_pkg::PROD_W-1:0] s6_pl_r, s6_pr_r;
  logic signed [bgi_pkg::PROD_W-1:0] s6_pl_nxt, s6_pr_nxt;
  logic signed [DW-1:0]              s6_al_r, s6_ar_r;
  logic [FB-1:0]                     s6_tx_r;

  always_comb begin
    s6_pl_nxt = bgi_pkg::PROD_W'(s5_dl_r) * bgi_pkg::PROD_W'($signed({1'b0, s5_ty_r}));
    s6_pr_nxt = bgi_pkg::PROD_W'(s5_dr_r) * bgi_pkg::PROD_W'($signed({1'b0, s5_ty_r}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_pl_r <= s6_pl_nxt;
      s6_pr_r <= s6_pr_nxt;
      s6_al_r <= s5_al_r;
      s6_ar_r <= s5_ar_r;
      s6_tx_r <= s5_tx_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: round to nearest (floor of p + half), add base -> left/right
  // ---------------------------------------------------------------------------
  logic signed [bgi_pkg::PROD_W-1:0] rnd_l, rnd_r;
  logic signed [DW-1:0]              s7_left_r, s7_right_r;
  logic [FB-1:0]                     s7_tx_r;

  always_comb begin
    rnd_l = s6_pl_r + bgi_pkg::ROUND_HALF;
    rnd_r = s6_pr_r + bgi_pkg::ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_left_r  <= s6_al_r + rnd_l[FB +: DW];
      s7_right_r <= s6_ar_r + rnd_r[FB +: DW];
      s7_tx_r    <= s6_tx_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: difference along x
  // ---------------------------------------------------------------------------
  logic signed [DW:0]   s8_d_r;
  logic signed [DW-1:0] s8_left_r;
  logic [FB-1:0]        s8_tx_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_d_r    <= $signed({s7_right_r[DW-1], s7_right_r}) -
                   $signed({s7_left_r[DW-1], s7_left_r});
      s8_left_r <= s7_left_r;
      s8_tx_r   <= s7_tx_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 9: weight the x difference
  // ---------------------------------------------------------------------------
  logic signed [bgi_pkg::PROD_W-1:0] s9_p_r, s9_p_nxt;
  logic signed [DW-1:0]              s9_left_r;

  assign s9_p_nxt = bgi_pkg::PROD_W'(s8_d_r) * bgi_pkg::PROD_W'($signed({1'b0, s8_tx_r}));

  always_ff @(posedge clk) begin
    if (en) begin
      s9_p_r    <= s9_p_nxt;
      s9_left_r <= s8_left_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: final rounding and add
  // ---------------------------------------------------------------------------
  logic signed [bgi_pkg::PROD_W-1:0] rnd_o;
  logic signed [DW-1:0]              out_value_r, out_value_nxt;

  always_comb begin
    rnd_o         = s9_p_r + bgi_pkg::ROUND_HALF;
    out_value_nxt = s9_left_r + rnd_o[FB +: DW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= out_value_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_value_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Clamped column stays in use; a far neighbor exists only below the edge
  a_col_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && s3_query_r) |->
      (s3_x1_r <= ncm1_x) && (!s3_xinc_r || s3_x1_r != ncm1_x))
    else $error("column index beyond the used grid");

  // Same for rows
  a_row_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && s3_query_r) |->
      (s3_y1_r <= ncm1_y) && (!s3_yinc_r || s3_y1_r != ncm1_y))
    else $error("row index beyond the used grid");

  // A write item ends at the memory stage and never turns into a result
  a_write_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s3_valid_r && !s3_query_r) |=> !s4_valid_r)
    else $error("write item entered the blend stages");

  // Only one bank takes a write at a time
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we))
    else $error("more than one grid bank written in a cycle");

endmodule

`default_nettype wire
